### rtl/csrt_pkg.sv
`timescale 1ns / 1ps

package csrt_pkg;

	localparam int NUM_STREAMS = 64;
	localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	localparam int CS_W = 6;
	localparam int FMT_W = 2;
	localparam int TIME_W = 32;
	localparam int LEN_W = 24;
	localparam int TYPE_W = 8;
	localparam int MSID_W = 32;

	localparam int CSR_DATA_W = 32;
	localparam int CSR_ADDR_W = 3;
	localparam int CSR_IDX_W = CSR_ADDR_W - 2;

	localparam logic [CSR_IDX_W-1:0] REG_RX_CHUNK_LEN = CSR_IDX_W'(0);
	localparam logic [LEN_W-1:0] RX_CHUNK_LEN_RESET = LEN_W'(128);

	localparam logic OP_CHUNK = 1'b0;
	localparam logic OP_ABORT = 1'b1;

	localparam logic [FMT_W-1:0] FMT_FULL = 2'd0;
	localparam logic [FMT_W-1:0] FMT_NO_ID = 2'd1;
	localparam logic [FMT_W-1:0] FMT_DELTA = 2'd2;
	localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] timestamp;
		logic [TIME_W-1:0] delta;
		logic [LEN_W-1:0] length;
		logic [TYPE_W-1:0] msg_type;
		logic [MSID_W-1:0] msg_id;
		logic [LEN_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic opcode;
		logic [CS_W-1:0] chunk_stream;
		logic [FMT_W-1:0] header_format;
		logic [TIME_W-1:0] time_value;
		logic [LEN_W-1:0] length_value;
		logic [TYPE_W-1:0] type_value;
		logic [MSID_W-1:0] stream_value;
	} item_t;

	typedef struct packed {
		logic [LEN_W-1:0] payload_bytes;
		logic message_done;
		logic overrun;
	} status_t;

	// Chunk stream id folded onto the table depth by restoring subtraction.
	function automatic idx_t stream_index(input logic [CS_W-1:0] cs);
		logic [CS_W:0] r;
		r = {1'b0, cs};
		for (int k = CS_W - 1; k >= 0; k--) begin
			if (int'(r) >= (NUM_STREAMS << k)) begin
				r = r - (CS_W + 1)'(NUM_STREAMS << k);
			end
		end
		return IDX_W'(r);
	endfunction

endpackage

### rtl/csrt_if.sv
`timescale 1ns / 1ps

interface csrt_hdr_if;
	import csrt_pkg::*;

	logic valid;
	logic ready;
	logic opcode;
	logic [CS_W-1:0] chunk_stream;
	logic [FMT_W-1:0] header_format;
	logic [TIME_W-1:0] time_value;
	logic [LEN_W-1:0] length_value;
	logic [TYPE_W-1:0] type_value;
	logic [MSID_W-1:0] stream_value;

	modport source (
		output valid, opcode, chunk_stream, header_format, time_value,
		output length_value, type_value, stream_value,
		input ready
	);

	modport sink (
		input valid, opcode, chunk_stream, header_format, time_value,
		input length_value, type_value, stream_value,
		output ready
	);
endinterface

interface csrt_res_if;
	import csrt_pkg::*;

	logic valid;
	logic ready;
	logic [LEN_W-1:0] payload_bytes;
	logic message_done;
	logic [CS_W-1:0] out_stream;
	logic [LEN_W-1:0] out_length;
	logic [TYPE_W-1:0] out_type;
	logic [MSID_W-1:0] out_message_stream;
	logic [TIME_W-1:0] out_timestamp;
	logic overrun;

	modport source (
		output valid, payload_bytes, message_done, out_stream, out_length,
		output out_type, out_message_stream, out_timestamp, overrun,
		input ready
	);

	modport sink (
		input valid, payload_bytes, message_done, out_stream, out_length,
		input out_type, out_message_stream, out_timestamp, overrun,
		output ready
	);
endinterface

### rtl/csrt_regs.sv
`timescale 1ns / 1ps

module csrt_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [csrt_pkg::CSR_ADDR_W-1:0] paddr,
	input  logic [csrt_pkg::CSR_DATA_W-1:0] pwdata,
	output logic [csrt_pkg::CSR_DATA_W-1:0] prdata,
	output logic pready,
	output logic [csrt_pkg::LEN_W-1:0] rx_chunk_len
);
	import csrt_pkg::*;

	logic [LEN_W-1:0] rx_chunk_len_q;
	logic [CSR_IDX_W-1:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[CSR_ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite && (reg_idx == REG_RX_CHUNK_LEN);
	assign pready = 1'b1;
	assign rx_chunk_len = rx_chunk_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_chunk_len_q <= RX_CHUNK_LEN_RESET;
		end else if (wr_en) begin
			rx_chunk_len_q <= pwdata[LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_RX_CHUNK_LEN: prdata = CSR_DATA_W'(rx_chunk_len_q);
			default: prdata = '0;
		endcase
	end
endmodule

### rtl/csrt_table.sv
`timescale 1ns / 1ps

module csrt_table (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  csrt_pkg::idx_t rd_addr,
	output csrt_pkg::entry_t rd_data,
	input  logic wr_en,
	input  csrt_pkg::idx_t wr_addr,
	input  csrt_pkg::entry_t wr_data
);
	import csrt_pkg::*;

	entry_t mem [NUM_STREAMS];
	logic [NUM_STREAMS-1:0] vld_q;
	entry_t raw_q;
	entry_t byp_q;
	logic byp_sel_q;
	logic raw_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_q <= mem[rd_addr];
			byp_q <= wr_data;
		end
	end

	// A write landing on the entry being read at the same edge wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			byp_sel_q <= 1'b0;
			raw_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				byp_sel_q <= wr_en && (wr_addr == rd_addr);
				raw_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		if (byp_sel_q) begin
			rd_data = byp_q;
		end else if (raw_vld_q) begin
			rd_data = raw_q;
		end else begin
			rd_data = '0;
		end
	end
endmodule

### rtl/csrt_update.sv
`timescale 1ns / 1ps

module csrt_update (
	input  csrt_pkg::item_t item,
	input  csrt_pkg::entry_t cur,
	input  logic [csrt_pkg::LEN_W-1:0] rx_chunk_len,
	output csrt_pkg::entry_t nxt,
	output csrt_pkg::status_t status
);
	import csrt_pkg::*;

	logic start;
	logic [TIME_W-1:0] addend;
	logic [TIME_W-1:0] ts_sum;
	logic [LEN_W-1:0] len_new;
	logic [LEN_W-1:0] csz;
	logic [LEN_W:0] diff;
	logic [LEN_W-1:0] rem;
	logic ovr;
	logic fits;

	assign start = (cur.count == '0);
	assign csz = (rx_chunk_len == '0) ? LEN_W'(1) : rx_chunk_len;
	assign addend = (item.header_format == FMT_NONE) ? cur.delta : item.time_value;
	assign ts_sum = cur.timestamp + addend;

	always_comb begin
		nxt = cur;
		unique case (item.header_format)
			FMT_FULL: begin
				if (start) begin
					nxt.delta = item.time_value - cur.timestamp;
				end
				nxt.timestamp = item.time_value;
				nxt.length = item.length_value;
				nxt.msg_type = item.type_value;
				nxt.msg_id = item.stream_value;
			end
			FMT_NO_ID: begin
				if (start) begin
					nxt.delta = item.time_value;
					nxt.timestamp = ts_sum;
				end
				nxt.length = item.length_value;
				nxt.msg_type = item.type_value;
			end
			FMT_DELTA: begin
				if (start) begin
					nxt.delta = item.time_value;
					nxt.timestamp = ts_sum;
				end
			end
			FMT_NONE: begin
				if (start) begin
					nxt.timestamp = ts_sum;
				end
			end
			default: nxt = cur;
		endcase
		if (item.opcode == OP_ABORT) begin
			nxt = cur;
		end

		len_new = nxt.length;
		diff = {1'b0, len_new} - {1'b0, cur.count};
		ovr = diff[LEN_W];
		rem = diff[LEN_W-1:0];
		fits = (rem <= csz);

		status = '0;
		if (item.opcode == OP_ABORT) begin
			nxt.count = '0;
		end else if (ovr) begin
			status.overrun = 1'b1;
			nxt.count = '0;
		end else if (fits) begin
			status.payload_bytes = rem;
			status.message_done = 1'b1;
			nxt.count = '0;
		end else begin
			// Not the last chunk, so the sum stays below the length.
			status.payload_bytes = csz;
			nxt.count = cur.count + csz;
		end
	end
endmodule

### rtl/chunk_stream_reassembly_tracker.sv
`timescale 1ns / 1ps

// Chunk stream reassembly tracker. Each transaction on the header channel is
// one parsed chunk header (format 0 to 3) or an abort for one chunk stream,
// and produces exactly one transaction on the result channel: the payload
// bytes that follow the header (the smaller of the bytes left in the message
// and the receive chunk size, where a chunk size of zero counts as one), a
// message-done flag, an overrun flag and the stream's message metadata after
// the update. A header is accepted every clock cycle while the result side
// keeps up; its result goes from stage 1 into the result register. The rate
// is set by the per-stream table, a 64-entry memory with one read port and
// one write port: the entry is read at the accepting edge, updated while the
// header sits in stage 1, and written back at the edge that loads the result
// register. Back-to-back headers for the same stream see the fresh entry
// through a forwarding path around the memory. Reset clears the table at
// once through per-entry valid bits, so no clearing pass is needed. Chunk
// stream ids at or beyond the table depth fold onto it modulo the depth,
// while out_stream echoes the id as received. The receive chunk size is
// written through the APB port at byte address 0 and must only be changed
// while no transaction is in flight.
module chunk_stream_reassembly_tracker (
	input  logic clk,
	input  logic arst_n,
	csrt_hdr_if.sink header,
	csrt_res_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [csrt_pkg::CSR_ADDR_W-1:0] paddr,
	input  logic [csrt_pkg::CSR_DATA_W-1:0] pwdata,
	output logic [csrt_pkg::CSR_DATA_W-1:0] prdata,
	output logic pready
);
	import csrt_pkg::*;

	logic [LEN_W-1:0] rx_chunk_len;
	logic accept;
	logic advance;

	// Stage 1 holds the accepted header while its table entry is read.
	logic vld_s1;
	item_t item_s1;
	idx_t idx_s1;

	entry_t cur_entry;
	entry_t nxt_entry;
	status_t status;

	// Result register.
	logic res_vld_q;
	status_t res_status_q;
	logic [CS_W-1:0] res_stream_q;
	entry_t res_entry_q;

	item_t hdr_item;

	assign hdr_item.opcode = header.opcode;
	assign hdr_item.chunk_stream = header.chunk_stream;
	assign hdr_item.header_format = header.header_format;
	assign hdr_item.time_value = header.time_value;
	assign hdr_item.length_value = header.length_value;
	assign hdr_item.type_value = header.type_value;
	assign hdr_item.stream_value = header.stream_value;

	// Stage 1 moves on when the result register is free or being emptied;
	// a new header may enter in the same cycle.
	assign advance = vld_s1 && (!res_vld_q || result.ready);
	assign header.ready = !vld_s1 || advance;
	assign accept = header.valid && header.ready;

	csrt_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.rx_chunk_len(rx_chunk_len)
	);

	csrt_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(accept),
		.rd_addr(stream_index(header.chunk_stream)),
		.rd_data(cur_entry),
		.wr_en(advance),
		.wr_addr(idx_s1),
		.wr_data(nxt_entry)
	);

	csrt_update u_update (
		.item(item_s1),
		.cur(cur_entry),
		.rx_chunk_len(rx_chunk_len),
		.nxt(nxt_entry),
		.status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= hdr_item;
			idx_s1 <= stream_index(header.chunk_stream);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_status_q <= status;
			res_stream_q <= item_s1.chunk_stream;
			res_entry_q <= nxt_entry;
		end
	end

	assign result.valid = res_vld_q;
	assign result.payload_bytes = res_status_q.payload_bytes;
	assign result.message_done = res_status_q.message_done;
	assign result.overrun = res_status_q.overrun;
	assign result.out_stream = res_stream_q;
	assign result.out_length = res_entry_q.length;
	assign result.out_type = res_entry_q.msg_type;
	assign result.out_message_stream = res_entry_q.msg_id;
	assign result.out_timestamp = res_entry_q.timestamp;

`ifndef SYNTHESIS
	// A stalled result must block stage 1 and therefore the header side.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && res_vld_q && !result.ready |-> !header.ready)
		else $error("header accepted while result stalled and stage 1 full");

	// An accepted header always occupies stage 1 in the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted header lost before stage 1");

	// Every table write-back is matched by a loaded result.
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_vld_q)
		else $error("result register not loaded after write-back");

	// A chunk cannot both complete its message and report an overrun.
	a_done_xor_ovr: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> !(res_status_q.message_done && res_status_q.overrun))
		else $error("message done and overrun both set");

	// An overrun result never carries payload.
	a_ovr_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_status_q.overrun |-> res_status_q.payload_bytes == '0)
		else $error("overrun result with nonzero payload");
`endif
endmodule
